// ===== sv/dsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared widths, character codes, unit lengths and pipeline word types of the
// duration string parser.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int unsigned SEC_W  = 64;
  localparam int unsigned UNIT_W = 25;
  localparam int unsigned CHAR_W = 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_0    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_Y_LO = 8'h79;
  localparam logic [CHAR_W-1:0] CHAR_Y_UP = 8'h59;
  localparam logic [CHAR_W-1:0] CHAR_W_LO = 8'h77;
  localparam logic [CHAR_W-1:0] CHAR_W_UP = 8'h57;
  localparam logic [CHAR_W-1:0] CHAR_D_LO = 8'h64;
  localparam logic [CHAR_W-1:0] CHAR_D_UP = 8'h44;
  localparam logic [CHAR_W-1:0] CHAR_H_LO = 8'h68;
  localparam logic [CHAR_W-1:0] CHAR_H_UP = 8'h48;
  localparam logic [CHAR_W-1:0] CHAR_M_LO = 8'h6d;
  localparam logic [CHAR_W-1:0] CHAR_M_UP = 8'h4d;
  localparam logic [CHAR_W-1:0] CHAR_S_LO = 8'h73;
  localparam logic [CHAR_W-1:0] CHAR_S_UP = 8'h53;

  // Unit lengths in seconds
  localparam logic [UNIT_W-1:0] SEC_YEAR   = 25'd31557600;
  localparam logic [UNIT_W-1:0] SEC_WEEK   = 25'd604800;
  localparam logic [UNIT_W-1:0] SEC_DAY    = 25'd86400;
  localparam logic [UNIT_W-1:0] SEC_HOUR   = 25'd3600;
  localparam logic [UNIT_W-1:0] SEC_MINUTE = 25'd60;
  localparam logic [UNIT_W-1:0] SEC_SECOND = 25'd1;
  localparam logic [UNIT_W-1:0] SEC_NONE   = 25'd0;

  // Word from the front stage to the scaling stages
  typedef struct packed {
    logic              has_term;
    logic              last;
    logic              bad;
    logic              wrap;
    logic [UNIT_W-1:0] k;
    logic [SEC_W-1:0]  op;
  } front_word_t;

  // Word from the scaling stages to the accumulator
  typedef struct packed {
    logic             has_term;
    logic             last;
    logic             bad;
    logic             wrap;
    logic [SEC_W-1:0] term;
  } term_word_t;

  // Seconds per unit letter, zero for any other byte
  function automatic logic [UNIT_W-1:0] unit_seconds(input logic [CHAR_W-1:0] c);
    logic [UNIT_W-1:0] r;
    unique case (c)
      CHAR_Y_LO, CHAR_Y_UP: r = SEC_YEAR;
      CHAR_W_LO, CHAR_W_UP: r = SEC_WEEK;
      CHAR_D_LO, CHAR_D_UP: r = SEC_DAY;
      CHAR_H_LO, CHAR_H_UP: r = SEC_HOUR;
      CHAR_M_LO, CHAR_M_UP: r = SEC_MINUTE;
      CHAR_S_LO, CHAR_S_UP: r = SEC_SECOND;
      default:              r = SEC_NONE;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/dsp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_front
// Input register, character decode and the pending decimal number. Emits one
// word per character with the operand and unit length to be scaled.
// ----------------------------------------------------------------------------
module dsp_front
  import dsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              is_last,
  output logic              b_valid,
  output front_word_t       b_word
);

  logic              a_valid;
  logic [CHAR_W-1:0] a_char;
  logic              a_last;

  logic [SEC_W-1:0]  pending;
  logic [SEC_W-1:0]  pending_next;
  logic              bad;
  logic              bad_next;
  front_word_t       word_next;

  logic                is_digit;
  logic [CHAR_W-1:0]   char_diff;
  logic [3:0]          digit;
  logic [UNIT_W-1:0]   k_unit;
  logic [SEC_W+3:0]    p_ext;
  logic [SEC_W+3:0]    times10;
  logic [SEC_W:0]      with_digit;
  logic                digit_wrap;

  // Hold the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
    if (adv) begin
      a_char <= char_code;
      a_last <= is_last;
    end
  end

  // Decode the character and extend the pending number
  always_comb begin
    is_digit   = (a_char >= CHAR_0) && (a_char <= CHAR_9);
    char_diff  = a_char - CHAR_0;
    digit      = char_diff[3:0];
    k_unit     = unit_seconds(a_char);
    p_ext      = {4'b0, pending};
    times10    = (p_ext << 3) + (p_ext << 1);
    with_digit = {1'b0, times10[SEC_W-1:0]} + {{(SEC_W-3){1'b0}}, digit};
    digit_wrap = (|times10[SEC_W+3:SEC_W]) | with_digit[SEC_W];
  end

  // Next state and the word for the scaling stages
  always_comb begin
    pending_next       = pending;
    bad_next           = bad;
    word_next.has_term = 1'b0;
    word_next.last     = a_last;
    word_next.wrap     = 1'b0;
    word_next.k        = SEC_SECOND;
    word_next.op       = pending;
    if (!bad) begin
      if (is_digit) begin
        pending_next   = with_digit[SEC_W-1:0];
        word_next.wrap = digit_wrap;
        // trailing bare number counts as seconds
        if (a_last) begin
          word_next.has_term = 1'b1;
          word_next.op       = with_digit[SEC_W-1:0];
        end
      end else if (k_unit != SEC_NONE) begin
        word_next.has_term = 1'b1;
        word_next.k        = k_unit;
        pending_next       = '0;
      end else begin
        bad_next = 1'b1;
      end
    end
    word_next.bad = bad_next;
    // restart for the next string
    if (a_last) begin
      pending_next = '0;
      bad_next     = 1'b0;
    end
  end

  // Advance the parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      bad     <= 1'b0;
    end else if (adv && a_valid) begin
      pending <= pending_next;
      bad     <= bad_next;
    end
  end

  // Hold the outgoing word
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
    if (adv) begin
      b_word <= word_next;
    end
  end

endmodule

// ===== sv/dsp_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_scale
// Two-stage multiply of the operand by the unit length: 32x25 partial
// products in the first stage, their sum and the wrap check in the second.
// ----------------------------------------------------------------------------
module dsp_scale
  import dsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        b_valid,
  input  front_word_t b_word,
  output logic        d_valid,
  output term_word_t  d_word
);

  localparam int unsigned HALF_W = SEC_W / 2;
  localparam int unsigned PP_W   = HALF_W + UNIT_W;
  localparam int unsigned FULL_W = HALF_W + PP_W;

  logic              c_valid;
  logic              c_has_term;
  logic              c_last;
  logic              c_bad;
  logic              c_wrap;
  logic [PP_W-1:0]   c_lo;
  logic [PP_W-1:0]   c_hi;
  logic [FULL_W-1:0] full;

  // Form the partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
    if (adv) begin
      c_has_term <= b_word.has_term;
      c_last     <= b_word.last;
      c_bad      <= b_word.bad;
      c_wrap     <= b_word.wrap;
      c_lo       <= b_word.op[HALF_W-1:0] * b_word.k;
      c_hi       <= b_word.op[SEC_W-1:HALF_W] * b_word.k;
    end
  end

  // Sum the partial products
  assign full = {{HALF_W{1'b0}}, c_lo} + {c_hi, {HALF_W{1'b0}}};

  // Hold the scaled term; any bit above the word is a wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
    if (adv) begin
      d_word.has_term <= c_has_term;
      d_word.last     <= c_last;
      d_word.bad      <= c_bad;
      d_word.wrap     <= c_wrap | (c_has_term & (|full[FULL_W-1:SEC_W]));
      d_word.term     <= full[SEC_W-1:0];
    end
  end

endmodule

// ===== sv/duration_string_parser_core.sv =====
`timescale 1ns / 1ps
// Path: an accepted character is held in the input register, then in the front
//   word, partial-product and scaled-term registers, before its result word loads.
// Throughput: one character per cycle while the result word is not stalled,
//   set by the pending-number loop and the running-total adder.
// A stalled result word holds the whole pipeline and drops in_ready.
// Reset: synchronous rst clears the parse state, totals and all valid bits.
// ----------------------------------------------------------------------------
// duration_string_parser_core
// Parses a duration string one character per word into seconds, with
// validity and wrap reporting on the final character.
// ----------------------------------------------------------------------------
module duration_string_parser_core
  import dsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              is_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              valid_res,
  output logic [SEC_W-1:0]  seconds,
  output logic              overflowed
);

  logic        adv;
  logic        b_valid;
  front_word_t b_word;
  logic        d_valid;
  term_word_t  d_word;

  logic [SEC_W-1:0] total;
  logic             wrap_acc;
  logic [SEC_W-1:0] addend;
  logic [SEC_W:0]   sum;
  logic             wrap_all;

  // Advance whenever the result register is free or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  dsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .char_code (char_code),
    .is_last   (is_last),
    .b_valid   (b_valid),
    .b_word    (b_word)
  );

  dsp_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .b_valid (b_valid),
    .b_word  (b_word),
    .d_valid (d_valid),
    .d_word  (d_word)
  );

  // Add the scaled term to the running total
  always_comb begin
    addend   = d_word.has_term ? d_word.term : '0;
    sum      = {1'b0, total} + {1'b0, addend};
    wrap_all = wrap_acc | d_word.wrap | sum[SEC_W];
  end

  // Accumulate, restart after the final character
  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      wrap_acc <= 1'b0;
    end else if (adv && d_valid) begin
      if (d_word.last) begin
        total    <= '0;
        wrap_acc <= 1'b0;
      end else begin
        total    <= sum[SEC_W-1:0];
        wrap_acc <= wrap_all;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid && d_word.last;
    end
    if (adv && d_valid && d_word.last) begin
      valid_res  <= !d_word.bad;
      seconds    <= d_word.bad ? '0 : sum[SEC_W-1:0];
      overflowed <= wrap_all;
    end
  end

endmodule

// ===== sv/dsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_checker
// Port-level checks of the duration string parser, bound to the top level.
// ----------------------------------------------------------------------------
module dsp_checker
  import dsp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              valid_res,
  input logic [SEC_W-1:0]  seconds,
  input logic              overflowed
);

  // A stalled result word holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(seconds)
      && $stable(valid_res) && $stable(overflowed))
    else $error("result word changed while stalled");

  // An invalid string reports zero seconds
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> seconds == '0)
    else $error("invalid string with nonzero seconds");

  // Input side stalls only behind a stalled result word
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind duration_string_parser_core dsp_checker u_dsp_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives duration strings into duration_string_parser_core one character word
// at a time and checks every result word against a bit-exact parse predictor
// or, for most of the short table of directed strings that runs first, a
// listed result. Random well-formed, broken and noise strings follow, with random
// idling on both channels and one long receiver hold-off that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import dsp_pkg::*;

  localparam int unsigned RANDOM_WORDS   = 500;
  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam int unsigned SQUEEZE_AFTER  = 150;
  localparam int unsigned SQUEEZE_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam logic [SEC_W-1:0] DECIMAL_BASE = 64'd10;

  typedef struct packed {
    logic             valid_res;
    logic [SEC_W-1:0] seconds;
    logic             overflowed;
  } dur_result_t;

  typedef struct {
    logic [CHAR_W-1:0] chr;
    logic              last;
    bit                has_want;
    dur_result_t       want;
  } char_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAR_W-1:0] char_code = '0;
  logic              is_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              valid_res;
  logic [SEC_W-1:0]  seconds;
  logic              overflowed;

  char_word_t        char_words[$];
  logic [CHAR_W-1:0] draft[$];
  dur_result_t       due_results[$];
  char_word_t        cur_word;

  // Parse state of the predictor
  logic [SEC_W-1:0] num_acc;
  logic [SEC_W-1:0] total_acc;
  logic             bad_seen;
  logic             wrap_seen;

  int unsigned cycle_count    = 0;
  int unsigned chars_accepted = 0;
  int unsigned total_chars    = 0;
  int unsigned results_seen   = 0;
  int unsigned error_count    = 0;
  int unsigned gap_left       = 0;
  int unsigned hold_left      = 0;
  bit          squeeze_done   = 1'b0;
  logic        calm;

  duration_string_parser_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .valid_res  (valid_res),
    .seconds    (seconds),
    .overflowed (overflowed)
  );

  always #5 clk = ~clk;

  // Run both channels without idling while the cycle count sits in the calm window
  assign calm = (cycle_count % 1000) < 150;

  // ---------------------------------------------------------------- predictor

  function automatic logic [SEC_W-1:0] unit_len(input logic [CHAR_W-1:0] c);
    case (c)
      CHAR_Y_LO, CHAR_Y_UP: return 64'(SEC_YEAR);
      CHAR_W_LO, CHAR_W_UP: return 64'(SEC_WEEK);
      CHAR_D_LO, CHAR_D_UP: return 64'(SEC_DAY);
      CHAR_H_LO, CHAR_H_UP: return 64'(SEC_HOUR);
      CHAR_M_LO, CHAR_M_UP: return 64'(SEC_MINUTE);
      CHAR_S_LO, CHAR_S_UP: return 64'(SEC_SECOND);
      default:              return 64'(SEC_NONE);
    endcase
  endfunction

  function automatic logic [SEC_W-1:0] mul_wrap(input logic [SEC_W-1:0] a,
                                                input logic [SEC_W-1:0] k);
    logic [2*SEC_W-1:0] prod;
    prod = {64'd0, a} * {64'd0, k};
    if (prod[2*SEC_W-1:SEC_W] != '0) wrap_seen = 1'b1;
    return prod[SEC_W-1:0];
  endfunction

  function automatic logic [SEC_W-1:0] add_wrap(input logic [SEC_W-1:0] a,
                                                input logic [SEC_W-1:0] b);
    logic [SEC_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum[SEC_W]) wrap_seen = 1'b1;
    return sum[SEC_W-1:0];
  endfunction

  task automatic clear_parse();
    num_acc   = '0;
    total_acc = '0;
    bad_seen  = 1'b0;
    wrap_seen = 1'b0;
  endtask

  // Advance the parse by one character; give the result on the final one
  task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last,
                            output bit got, output dur_result_t r);
    logic [SEC_W-1:0] k;
    got = 1'b0;
    r   = '0;
    if (!bad_seen) begin
      if (c >= CHAR_0 && c <= CHAR_9) begin
        num_acc = add_wrap(mul_wrap(num_acc, DECIMAL_BASE), 64'(c) - 64'(CHAR_0));
      end else begin
        k = unit_len(c);
        if (k == '0) begin
          bad_seen = 1'b1;
        end else begin
          total_acc = add_wrap(total_acc, mul_wrap(num_acc, k));
          num_acc   = '0;
        end
      end
    end
    if (last) begin
      got = 1'b1;
      if (!bad_seen) begin
        r.seconds   = add_wrap(total_acc, num_acc);
        r.valid_res = 1'b1;
      end
      r.overflowed = wrap_seen;
      clear_parse();
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic dur_result_t result_of(input logic v, input logic [SEC_W-1:0] s,
                                            input logic o);
    dur_result_t r;
    r.valid_res  = v;
    r.seconds    = s;
    r.overflowed = o;
    return r;
  endfunction

  task automatic add_char(input logic [CHAR_W-1:0] c, input logic last,
                          input bit has_want, input dur_result_t want);
    char_word_t w;
    w.chr      = c;
    w.last     = last;
    w.has_want = has_want;
    w.want     = want;
    char_words.push_back(w);
  endtask

  task automatic add_text(input string s, input bit has_want, input dur_result_t want);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i], i == s.len() - 1, has_want, want);
    end
  endtask

  // Move the drafted string into the stimulus, marking its final character
  task automatic flush_draft();
    for (int i = 0; i < draft.size(); i++) begin
      add_char(draft[i], i == draft.size() - 1, 1'b0, '0);
    end
    draft.delete();
  endtask

  function automatic int unsigned number_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 20);
  endfunction

  task automatic draft_number(input int unsigned n);
    repeat (n) draft.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
  endtask

  function automatic logic [CHAR_W-1:0] any_unit();
    case ($urandom_range(0, 11))
      0:       return CHAR_Y_LO;
      1:       return CHAR_Y_UP;
      2:       return CHAR_W_LO;
      3:       return CHAR_W_UP;
      4:       return CHAR_D_LO;
      5:       return CHAR_D_UP;
      6:       return CHAR_H_LO;
      7:       return CHAR_H_UP;
      8:       return CHAR_M_LO;
      9:       return CHAR_M_UP;
      10:      return CHAR_S_LO;
      default: return CHAR_S_UP;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] bad_byte();
    logic [CHAR_W-1:0] c;
    c = 8'($urandom_range(0, 255));
    while ((c >= CHAR_0 && c <= CHAR_9) || unit_len(c) != '0) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic build_directed();
    add_char(8'h00, 1'b1, 1'b1, result_of(1'b0, 64'd0, 1'b0));
    add_char(8'hFF, 1'b1, 1'b1, result_of(1'b0, 64'd0, 1'b0));
    // Bad byte in the middle: the digit after it is ignored
    add_text("1x9", 1'b1, result_of(1'b0, 64'd0, 1'b0));
    // Unit with no number in front of it
    add_text("Y", 1'b1, result_of(1'b1, 64'd0, 1'b0));
    // Mixed case units with a trailing bare number
    add_text("3W4H5m6S7", 1'b0, '0);
    // Years scaling wraps past 64 bits
    add_text("600000000000y", 1'b0, '0);
  endtask

  task automatic build_random();
    int unsigned made;
    int unsigned form;
    int unsigned terms;
    int unsigned bad_at;
    made = 0;
    while (made < RANDOM_WORDS) begin
      form = $urandom_range(0, 99);
      if (form < 15) begin
        // Noise: random bytes of any value
        repeat ($urandom_range(1, 6)) draft.push_back(8'($urandom_range(0, 255)));
      end else begin
        terms  = $urandom_range(0, 4);
        bad_at = (form < 35) ? $urandom_range(0, terms) : terms + 1;
        for (int t = 0; t < terms; t++) begin
          if (t == bad_at) draft.push_back(bad_byte());
          if ($urandom_range(0, 19) != 0) draft_number(number_len());
          draft.push_back(any_unit());
        end
        if (bad_at == terms) draft.push_back(bad_byte());
        if (terms == 0 || $urandom_range(0, 2) == 0) draft_number(number_len());
      end
      made += draft.size();
      flush_draft();
    end
  endtask

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // ------------------------------------------------------------ input channel

  // Account for the accepted word, then offer the next one or idle
  always @(posedge clk) begin
    bit          got;
    dur_result_t r;
    logic        offer;
    if (!rst) begin
      if (in_valid && in_ready) begin
        parse_char(cur_word.chr, cur_word.last, got, r);
        if (got) due_results.push_back(cur_word.has_want ? cur_word.want : r);
        chars_accepted++;
      end
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (char_words.size() != 0) begin
          cur_word = char_words.pop_front();
          offer    = 1'b1;
          char_code <= cur_word.chr;
          is_last   <= cur_word.last;
          gap_left = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        end
        in_valid <= offer;
      end
    end
  end

  // ----------------------------------------------------------- output channel

  // Hold ready low at random; once, hold it long enough to back up the input
  always @(posedge clk) begin
    if (!rst) begin
      if (!squeeze_done && chars_accepted >= SQUEEZE_AFTER) begin
        squeeze_done = 1'b1;
        hold_left    = SQUEEZE_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 15) begin
        hold_left = idle_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [SEC_W-1:0] got,
                                 input logic [SEC_W-1:0] want);
    $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    error_count++;
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    dur_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected word, seconds", seconds, 64'd0);
      end else begin
        want = due_results.pop_front();
        if (valid_res !== want.valid_res)
          report_mismatch("valid_res", 64'(valid_res), 64'(want.valid_res));
        if (seconds !== want.seconds)
          report_mismatch("seconds", seconds, want.seconds);
        if (overflowed !== want.overflowed)
          report_mismatch("overflowed", 64'(overflowed), 64'(want.overflowed));
      end
      results_seen++;
    end
  end

  // ----------------------------------------------------------------- control

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    clear_parse();
    build_directed();
    build_random();
    total_chars = char_words.size();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // Wait for every word to be taken, then for every result to drain
    while (chars_accepted < total_chars) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch("missing results, count", 64'(due_results.size()), 64'd0);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/dsp_pkg.sv
sv/dsp_front.sv
sv/dsp_scale.sv
sv/duration_string_parser_core.sv
sv/dsp_checker.sv
test/tb_top.sv
